// ===== rtl/core/tiled_texture_tile_rect_core_defines.svh =====
// Assertion helpers for the core files; only ttr_fifo includes them.
`ifndef TILED_TEXTURE_TILE_RECT_CORE_DEFINES_SVH
`define TILED_TEXTURE_TILE_RECT_CORE_DEFINES_SVH

// Condition that must never hold at a clock edge out of reset.
`define TTR_ASSERT_NEVER(lbl, bad) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(bad)) \
    else $error("%m: forbidden condition seen");

// Same-cycle implication.
`define TTR_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("%m: implication failed");

// Next-cycle implication.
`define TTR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/ttr_pkg.sv =====
package ttr_pkg;

  localparam int unsigned DimW       = 15;
  localparam int unsigned ExtW       = 16;
  localparam int unsigned TileW      = 10;
  localparam int unsigned IdxW       = 20;
  localparam int unsigned CoordW     = 10;
  localparam int unsigned LvlW       = 4;
  localparam int unsigned ProdW      = 20;
  localparam int unsigned PosW       = 19;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegTexWidth   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegTexHeight  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegBlockComp  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegTileWidth  = 4'd3;
  localparam logic [CfgIdxW-1:0] RegTileHeight = 4'd4;
  localparam logic [CfgIdxW-1:0] RegFirstMip   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegMipCount   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegPackStart  = 4'd7;

  localparam logic [PosW-1:0] PosMax  = '1;
  localparam logic [DimW-1:0] SizeMax = '1;

  typedef struct packed {
    logic [DimW-1:0]   texture_width;
    logic [DimW-1:0]   texture_height;
    logic              block_compressed;
    logic [TileW-1:0]  tile_width;
    logic [TileW-1:0]  tile_height;
    logic [LvlW-1:0]   first_packed_mip;
    logic [LvlW-1:0]   packed_mip_count;
    logic [IdxW-1:0]   packed_start_tile;
  } cfg_t;

  typedef struct packed {
    logic              packed_tile;
    logic [ProdW-1:0]  x;
    logic [ProdW-1:0]  y;
    logic [LvlW-1:0]   level;
  } job_t;

  // max(dim >> mip, 1), rounded up to a multiple of 4 for block formats
  function automatic logic [ExtW-1:0] mip_extent(input logic [DimW-1:0] dim,
                                                 input logic [LvlW-1:0] mip,
                                                 input logic bc);
    logic [ExtW-1:0] s;
    s = {1'b0, dim >> mip};
    if (s == '0) s = ExtW'(1);
    if (bc) s = (s + ExtW'(3)) & ~ExtW'(3);
    return s;
  endfunction

  function automatic logic [DimW-1:0] sat_size(input logic [ExtW-1:0] v);
    return (v > {1'b0, SizeMax}) ? SizeMax : v[DimW-1:0];
  endfunction

  function automatic logic [ExtW-1:0] clip_size(input logic [ProdW-1:0] pos,
                                                input logic [TileW-1:0] size,
                                                input logic [ExtW-1:0] ext);
    logic [ExtW-1:0] room;
    room = ext - pos[ExtW-1:0];
    if (pos >= {{(ProdW-ExtW){1'b0}}, ext}) return '0;
    if ({{(ExtW-TileW){1'b0}}, size} > room) return room;
    return {{(ExtW-TileW){1'b0}}, size};
  endfunction

endpackage

// ===== rtl/core/ttr_if.sv =====
interface ttr_tile_if import ttr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   tile_index;
  logic [CoordW-1:0] tile_col;
  logic [CoordW-1:0] tile_row;
  logic [LvlW-1:0]   tile_level;

  modport source (output valid, tile_index, tile_col, tile_row, tile_level, input ready);
  modport sink   (input valid, tile_index, tile_col, tile_row, tile_level, output ready);
endinterface

interface ttr_rect_if import ttr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PosW-1:0] rect_x;
  logic [PosW-1:0] rect_y;
  logic [LvlW-1:0] rect_level;
  logic [DimW-1:0] rect_width;
  logic [DimW-1:0] rect_height;
  logic            last;

  modport source (output valid, rect_x, rect_y, rect_level, rect_width, rect_height, last,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_level, rect_width, rect_height, last,
                  output ready);
endinterface

interface ttr_cfg_if import ttr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ttr_front.sv =====
module ttr_front import ttr_pkg::*; (
  ttr_tile_if.sink   tile_i,
  input  cfg_t       cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  assign tile_i.ready = !full_i;
  assign push_o       = tile_i.valid && !full_i;

  always_comb begin
    job_o.packed_tile = (tile_i.tile_index >= cfg_i.packed_start_tile);
    job_o.x           = ProdW'(tile_i.tile_col) * ProdW'(cfg_i.tile_width);
    job_o.y           = ProdW'(tile_i.tile_row) * ProdW'(cfg_i.tile_height);
    job_o.level       = tile_i.tile_level;
  end

endmodule

// ===== rtl/core/ttr_fifo.sv =====
`include "tiled_texture_tile_rect_core_defines.svh"

module ttr_fifo import ttr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  `TTR_ASSERT_NEVER(a_count_range, count_q > FullCnt)
  `TTR_ASSERT_IMPL(a_pop_not_empty, pop_i, !empty_o)
  `TTR_ASSERT_NEXT(a_push_counts, do_push && !do_pop, count_q == $past(count_q) + CntW'(1))

endmodule

// ===== rtl/core/ttr_back.sv =====
module ttr_back import ttr_pkg::*; #(
  parameter int unsigned MIP_LEVELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  job_t        job_i,
  output logic        pop_o,
  ttr_rect_if.source  rect_o
);

  localparam int unsigned CntW = LvlW + 1;
  localparam logic [CntW-1:0] MipLim = CntW'(MIP_LEVELS);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]      state_q, state_d;
  job_t            job_q;
  logic [LvlW-1:0] mip_q;
  logic [CntW-1:0] remain_q;
  logic [ExtW-1:0] ew_q, eh_q;

  logic            out_valid_q;
  logic [PosW-1:0] out_x_q, out_y_q;
  logic [LvlW-1:0] out_level_q;
  logic [DimW-1:0] out_w_q, out_h_q;
  logic            out_last_q;

  logic [CntW-1:0] pack_sum, pack_n;
  logic            slot_free, emit;

  assign pack_sum = {1'b0, cfg_i.first_packed_mip} + {1'b0, cfg_i.packed_mip_count};

  always_comb begin
    if ({1'b0, cfg_i.first_packed_mip} >= MipLim) begin
      pack_n = '0;
    end else if (pack_sum > MipLim) begin
      pack_n = MipLim - {1'b0, cfg_i.first_packed_mip};
    end else begin
      pack_n = {1'b0, cfg_i.packed_mip_count};
    end
  end

  assign slot_free = !out_valid_q || rect_o.ready;
  assign emit      = (state_q == StEmit) && slot_free;
  assign pop_o     = (state_q == StIdle) && !empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i && !(job_i.packed_tile && pack_n == '0)) state_d = StLoad;
      end
      StLoad: state_d = StEmit;
      StEmit: begin
        if (slot_free) state_d = (remain_q == CntW'(1)) ? StIdle : StLoad;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (rect_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q    <= job_i;
      mip_q    <= job_i.packed_tile ? cfg_i.first_packed_mip : job_i.level;
      remain_q <= job_i.packed_tile ? pack_n : CntW'(1);
    end
    if (state_q == StLoad) begin
      ew_q <= mip_extent(cfg_i.texture_width, mip_q, cfg_i.block_compressed);
      eh_q <= mip_extent(cfg_i.texture_height, mip_q, cfg_i.block_compressed);
    end
    if (emit) begin
      out_level_q <= mip_q;
      out_last_q  <= (remain_q == CntW'(1));
      if (job_q.packed_tile) begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_w_q <= sat_size(ew_q);
        out_h_q <= sat_size(eh_q);
      end else begin
        out_x_q <= (job_q.x > {1'b0, PosMax}) ? PosMax : job_q.x[PosW-1:0];
        out_y_q <= (job_q.y > {1'b0, PosMax}) ? PosMax : job_q.y[PosW-1:0];
        out_w_q <= sat_size(clip_size(job_q.x, cfg_i.tile_width, ew_q));
        out_h_q <= sat_size(clip_size(job_q.y, cfg_i.tile_height, eh_q));
      end
      remain_q <= remain_q - CntW'(1);
      mip_q    <= mip_q + LvlW'(1);
    end
  end

  assign rect_o.valid       = out_valid_q;
  assign rect_o.rect_x      = out_x_q;
  assign rect_o.rect_y      = out_y_q;
  assign rect_o.rect_level  = out_level_q;
  assign rect_o.rect_width  = out_w_q;
  assign rect_o.rect_height = out_h_q;
  assign rect_o.last        = out_last_q;

endmodule

// ===== rtl/core/tiled_texture_tile_rect_core.sv =====
// Channel   Dir  Role    Payload
// tile_i    in   sink    tile_index, tile_col, tile_row, tile_level
// rect_o    out  source  rect_x, rect_y, rect_level, rect_width, rect_height, last
// cfg_i     in   sink    index, data (always ready)
//
// Front takes a tile item each cycle while the 2-entry queue has room.
// Back: a standard tile goes through dequeue, extent and emit; a packed tile is
// dequeued, then the extent/emit loop runs once for each of its n packed mips.
// Output register lets the back run one rectangle ahead of a stalled sink.
// rst_ni clears queue, back sequencer and output valid; config registers reset to defaults.
module tiled_texture_tile_rect_core import ttr_pkg::*; #(
  parameter int unsigned MIP_LEVELS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttr_tile_if.sink   tile_i,
  ttr_rect_if.source rect_o,
  ttr_cfg_if.sink    cfg_i
);

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic push, pop, full, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.texture_width     <= DimW'(1);
      cfg_q.texture_height    <= DimW'(1);
      cfg_q.block_compressed  <= 1'b0;
      cfg_q.tile_width        <= TileW'(128);
      cfg_q.tile_height       <= TileW'(128);
      cfg_q.first_packed_mip  <= '0;
      cfg_q.packed_mip_count  <= '0;
      cfg_q.packed_start_tile <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegTexWidth:   cfg_q.texture_width     <= cfg_i.data[DimW-1:0];
        RegTexHeight:  cfg_q.texture_height    <= cfg_i.data[DimW-1:0];
        RegBlockComp:  cfg_q.block_compressed  <= cfg_i.data[0];
        RegTileWidth:  cfg_q.tile_width        <= cfg_i.data[TileW-1:0];
        RegTileHeight: cfg_q.tile_height       <= cfg_i.data[TileW-1:0];
        RegFirstMip:   cfg_q.first_packed_mip  <= cfg_i.data[LvlW-1:0];
        RegMipCount:   cfg_q.packed_mip_count  <= cfg_i.data[LvlW-1:0];
        RegPackStart:  cfg_q.packed_start_tile <= cfg_i.data[IdxW-1:0];
        default: ;
      endcase
    end
  end

  ttr_front u_front (
    .tile_i (tile_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  ttr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  ttr_back #(.MIP_LEVELS(MIP_LEVELS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (head_job),
    .pop_o   (pop),
    .rect_o  (rect_o)
  );

endmodule

// ===== tb/tiled_texture_tile_rect_core_test.sv =====
module tiled_texture_tile_rect_core_test import ttr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MipLevels     = 16;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 60;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned MaxCycles     = 1_000_000;
  localparam int unsigned PosLimit      = 524287;
  localparam int unsigned SizeLimit     = 32767;

  typedef struct packed {
    logic [IdxW-1:0]   index;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [LvlW-1:0]   level;
  } tile_t;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [LvlW-1:0] level;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            last;
  } rect_t;

  typedef enum logic {StepWrite, StepTile} step_e;
  typedef enum logic [1:0] {CheckModel, CheckNone, CheckOne} check_e;

  typedef struct {
    step_e               kind;
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] value;
    tile_t               tile;
    check_e              mode;
    rect_t               rect;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttr_tile_if tile_bus ();
  ttr_rect_if rect_bus ();
  ttr_cfg_if  cfg_bus ();

  tiled_texture_tile_rect_core #(
    .MIP_LEVELS(MipLevels)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tile_i(tile_bus),
    .rect_o(rect_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cfg_t        regs;
  rect_t       expected_rects[$];
  step_t       directed_steps[$];
  int          errors;
  int unsigned cycles;
  int unsigned stall_left;
  bit          calm;

  function automatic int unsigned level_extent(input int unsigned dim, input int unsigned lvl);
    int unsigned s;
    s = dim >> lvl;
    if (s == 0) s = 1;
    if (regs.block_compressed) s = ((s + 3) / 4) * 4;
    return s;
  endfunction

  function automatic int unsigned clipped(input int unsigned pos, input int unsigned size,
                                          input int unsigned ext);
    if (pos >= ext) return 0;
    if (size > ext - pos) return ext - pos;
    return size;
  endfunction

  function automatic logic [DimW-1:0] sat_size(input int unsigned v);
    return (v > SizeLimit) ? '1 : DimW'(v);
  endfunction

  function automatic void predict_rects(input tile_t t);
    int unsigned n, mip, x, y;
    rect_t r;
    if (t.index >= regs.packed_start_tile) begin
      n = regs.packed_mip_count;
      if (regs.first_packed_mip >= MipLevels) n = 0;
      else if (regs.first_packed_mip + n > MipLevels) n = MipLevels - regs.first_packed_mip;
      for (int unsigned k = 0; k < n; k++) begin
        mip = regs.first_packed_mip + k;
        r.x      = '0;
        r.y      = '0;
        r.level  = LvlW'(mip);
        r.width  = sat_size(level_extent(regs.texture_width, mip));
        r.height = sat_size(level_extent(regs.texture_height, mip));
        r.last   = (k + 1 == n);
        expected_rects.insert(expected_rects.size(), r);
      end
    end else begin
      x = t.col * regs.tile_width;
      y = t.row * regs.tile_height;
      r.x      = (x > PosLimit) ? '1 : PosW'(x);
      r.y      = (y > PosLimit) ? '1 : PosW'(y);
      r.level  = t.level;
      r.width  = sat_size(clipped(x, regs.tile_width, level_extent(regs.texture_width, t.level)));
      r.height = sat_size(clipped(y, regs.tile_height,
                                  level_extent(regs.texture_height, t.level)));
      r.last   = 1'b1;
      expected_rects.insert(expected_rects.size(), r);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] value);
    step_t s;
    s = '{kind: StepWrite, reg_index: idx, value: value, tile: '0, mode: CheckNone, rect: '0};
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic void add_tile(input tile_t t, input check_e mode, input rect_t r);
    step_t s;
    s = '{kind: StepTile, reg_index: '0, value: '0, tile: t, mode: mode, rect: r};
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [CfgDataW-1:0] random_dim();
    case ($urandom_range(0, 4))
      0: return CfgDataW'($urandom_range(1, 64));
      1: return CfgDataW'($urandom_range(1, 16384));
      2: return CfgDataW'($urandom_range(0, 32767));
      3: return ($urandom_range(0, 1) != 0) ? CfgDataW'(32767) : CfgDataW'(16384);
      default: return CfgDataW'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] random_tile_size();
    case ($urandom_range(0, 3))
      0: return CfgDataW'($urandom_range(1, 16));
      1: return CfgDataW'($urandom_range(1, 512));
      2: return CfgDataW'($urandom_range(0, 1023));
      default: return CfgDataW'(1 << $urandom_range(0, 9));
    endcase
  endfunction

  function automatic int unsigned coord_limit(input int unsigned dim, input int unsigned size);
    int unsigned lim;
    lim = (size == 0) ? 4 : dim / size + 2;
    return (lim > 1023) ? 1023 : lim;
  endfunction

  function automatic tile_t random_tile();
    tile_t t;
    int unsigned s;
    s = regs.packed_start_tile;
    case ($urandom_range(0, 3))
      0: t.index = IdxW'($urandom());
      1: t.index = (s == 0) ? '0 : IdxW'($urandom_range(0, s - 1));
      2: t.index = (s > 1048571) ? '1 : IdxW'(s + $urandom_range(0, 3));
      default: t.index = IdxW'($urandom_range(0, 1023));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      t.col = CoordW'($urandom());
      t.row = CoordW'($urandom());
    end else begin
      t.col = CoordW'($urandom_range(0, coord_limit(regs.texture_width, regs.tile_width)));
      t.row = CoordW'($urandom_range(0, coord_limit(regs.texture_height, regs.tile_height)));
    end
    t.level = LvlW'($urandom_range(0, 15));
    return t;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      RegTexWidth:   regs.texture_width     = value[DimW-1:0];
      RegTexHeight:  regs.texture_height    = value[DimW-1:0];
      RegBlockComp:  regs.block_compressed  = value[0];
      RegTileWidth:  regs.tile_width        = value[TileW-1:0];
      RegTileHeight: regs.tile_height       = value[TileW-1:0];
      RegFirstMip:   regs.first_packed_mip  = value[LvlW-1:0];
      RegMipCount:   regs.packed_mip_count  = value[LvlW-1:0];
      RegPackStart:  regs.packed_start_tile = value[IdxW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_tile(input tile_t t, input check_e mode, input rect_t r);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    tile_bus.valid      <= 1'b1;
    tile_bus.tile_index <= t.index;
    tile_bus.tile_col   <= t.col;
    tile_bus.tile_row   <= t.row;
    tile_bus.tile_level <= t.level;
    do @(posedge clk_i); while (!tile_bus.ready);
    case (mode)
      CheckModel: predict_rects(t);
      CheckOne:   expected_rects.insert(expected_rects.size(), r);
      default: ;
    endcase
    if (gap != 0) begin
      @(negedge clk_i);
      tile_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // items that give no rectangle may still be in flight once the queue is empty
  task automatic settle();
    @(negedge clk_i);
    tile_bus.valid <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20)
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (stall_left != 0) begin
      rect_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      rect_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : rect_monitor
    rect_t want;
    if (rst_ni && rect_bus.valid && rect_bus.ready) begin
      if (expected_rects.size() == 0) begin
        $error("rectangle with no item pending: x %0d y %0d level %0d",
               rect_bus.rect_x, rect_bus.rect_y, rect_bus.rect_level);
        errors++;
      end else begin
        want = expected_rects.pop_front();
        check_field("rect_x", want.x, rect_bus.rect_x);
        check_field("rect_y", want.y, rect_bus.rect_y);
        check_field("rect_level", want.level, rect_bus.rect_level);
        check_field("rect_width", want.width, rect_bus.rect_width);
        check_field("rect_height", want.height, rect_bus.rect_height);
        check_field("last", want.last, rect_bus.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MaxCycles) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    step_t s;
    bit    quiet;
    errors     = 0;
    cycles     = 0;
    stall_left = 0;
    calm       = 1'b0;
    quiet      = 1'b1;
    rst_ni     = 1'b0;
    tile_bus.valid      = 1'b0;
    tile_bus.tile_index = '0;
    tile_bus.tile_col   = '0;
    tile_bus.tile_row   = '0;
    tile_bus.tile_level = '0;
    rect_bus.ready      = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    regs = '{texture_width: 1, texture_height: 1, block_compressed: 0, tile_width: 128,
             tile_height: 128, first_packed_mip: 0, packed_mip_count: 0,
             packed_start_tile: 0};

    // defaults after reset: every tile packed, no packed mips
    add_tile('{0, 0, 0, 0}, CheckNone, '0);
    add_tile('{20'hFFFFF, 10'h3FF, 10'h3FF, 4'hF}, CheckNone, '0);

    add_write(RegTexWidth, 200);
    add_write(RegTexHeight, 128);
    add_write(RegBlockComp, 0);
    add_write(RegTileWidth, 64);
    add_write(RegTileHeight, 32);
    add_write(RegFirstMip, 3);
    add_write(RegMipCount, 2);
    add_write(RegPackStart, 100);
    add_tile('{5, 1, 2, 0}, CheckOne, '{64, 64, 0, 64, 32, 1});
    add_tile('{5, 3, 3, 1}, CheckOne, '{192, 96, 1, 0, 0, 1});
    add_tile('{5, 0, 0, 3}, CheckOne, '{0, 0, 3, 25, 16, 1});
    add_tile('{99, 1023, 1023, 0}, CheckOne, '{65472, 32736, 0, 0, 0, 1});
    add_tile('{5, 0, 0, 15}, CheckOne, '{0, 0, 15, 1, 1, 1});
    add_tile('{5, 3, 1, 0}, CheckOne, '{192, 32, 0, 8, 32, 1});
    add_tile('{100, 0, 0, 0}, CheckModel, '0);
    add_tile('{20'hFFFFF, 0, 0, 0}, CheckModel, '0);

    add_write(RegTexWidth, 32767);
    add_write(RegTexHeight, 32767);
    add_write(RegBlockComp, 1);
    add_write(RegTileWidth, 1023);
    add_write(RegTileHeight, 0);
    add_write(RegFirstMip, 14);
    add_write(RegMipCount, 15);
    add_write(RegPackStart, 20'hFFFFF);
    add_tile('{0, 1023, 5, 0}, CheckOne, '{524287, 0, 0, 0, 0, 1});
    add_tile('{0, 0, 0, 0}, CheckOne, '{0, 0, 0, 1023, 0, 1});
    add_tile('{20'hFFFFF, 0, 0, 0}, CheckModel, '0);
    add_tile('{20'hFFFFE, 512, 0, 15}, CheckOne, '{523776, 0, 15, 0, 0, 1});

    add_write(RegTexHeight, 32766);
    add_write(RegFirstMip, 0);
    add_write(RegMipCount, 1);
    add_write(RegPackStart, 0);
    add_tile('{0, 0, 0, 0}, CheckOne, '{0, 0, 0, 32767, 32767, 1});

    add_write(RegTexWidth, 0);
    add_write(RegTexHeight, 0);
    add_write(RegBlockComp, 0);
    add_write(RegTileWidth, 5);
    add_write(RegTileHeight, 7);
    add_write(RegFirstMip, 15);
    add_write(RegMipCount, 15);
    add_write(RegPackStart, 2);
    add_tile('{1, 0, 0, 0}, CheckOne, '{0, 0, 0, 1, 1, 1});
    add_tile('{1, 1, 1, 0}, CheckOne, '{5, 7, 0, 0, 0, 1});
    add_tile('{2, 0, 0, 0}, CheckOne, '{0, 0, 15, 1, 1, 1});
    add_write(RegBlockComp, 1);
    add_tile('{1, 0, 0, 0}, CheckOne, '{0, 0, 0, 4, 4, 1});
    add_write(RegTileWidth, 0);
    add_write(RegMipCount, 0);
    add_tile('{0, 7, 0, 0}, CheckOne, '{0, 0, 0, 0, 4, 1});
    add_tile('{3, 0, 0, 0}, CheckNone, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.kind == StepWrite) begin
        if (!quiet) settle();
        quiet = 1'b1;
        write_reg(s.reg_index, s.value);
      end else begin
        quiet = 1'b0;
        send_tile(s.tile, s.mode, s.rect);
      end
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      settle();
      calm = (phase % 3 == 2);
      write_reg(RegTexWidth, random_dim());
      write_reg(RegTexHeight, random_dim());
      write_reg(RegBlockComp, CfgDataW'($urandom_range(0, 1)));
      write_reg(RegTileWidth, random_tile_size());
      write_reg(RegTileHeight, random_tile_size());
      write_reg(RegFirstMip, CfgDataW'($urandom_range(0, 15)));
      write_reg(RegMipCount, ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, 15))
                                                          : CfgDataW'($urandom_range(0, 4)));
      case ($urandom_range(0, 3))
        0: write_reg(RegPackStart, 0);
        1: write_reg(RegPackStart, CfgDataW'($urandom_range(0, 20'hFFFFF)));
        2: write_reg(RegPackStart, CfgDataW'($urandom_range(1, 1024)));
        default: write_reg(RegPackStart, 20'hFFFFF);
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) send_tile(random_tile(), CheckModel, '0);
    end

    settle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
